// ----- sv/bcc_pkg.sv -----
// Package for the button click classifier: types, register map and limits.
`default_nettype none
package bcc_pkg;

   // Field widths
   localparam int TIME_W     = 32;
   localparam int CFG_TIME_W = 16;
   localparam int CLICKS_W   = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Click counter limit set by the width of the count field
   localparam int CLICK_CAP_MAX = 15;
   localparam int MAX_CLICKS_DEFAULT = 15;

   // Reset values of the configuration registers
   localparam logic [CFG_TIME_W-1:0] BOUNCE_TIME_RESET     = 16'd50;
   localparam logic [CFG_TIME_W-1:0] LONG_CLICK_TIME_RESET = 16'd1000;

   // Register index (byte address divided by four)
   typedef enum logic [2:0] {
      REG_BOUNCE_TIME     = 3'd0,
      REG_LONG_CLICK_TIME = 3'd1,
      REG_ACTIVE_LOW      = 3'd2,
      REG_PRESS_NOTIFY    = 3'd3,
      REG_RELEASE_NOTIFY  = 3'd4
   } bcc_reg_type;

   // Event codes reported with each item
   typedef enum logic [1:0] {
      EVT_NONE       = 2'd0,
      EVT_LONG_PRESS = 2'd1,
      EVT_LONG_CLICK = 2'd2,
      EVT_BURST_END  = 2'd3
   } bcc_event_type;

   typedef struct packed {
      logic [CFG_TIME_W-1:0] bounce_time_ms;
      logic [CFG_TIME_W-1:0] long_click_time_ms;
      logic                  active_low;
      logic                  press_notify_enable;
      logic                  release_notify_enable;
   } bcc_cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]   held_duration;
      logic [TIME_W-1:0]   previous_sample_time;
      logic [TIME_W-1:0]   last_click_time;
      logic                long_reported;
      logic                press_reported;
      logic [CLICKS_W-1:0] short_clicks;
   } bcc_state_type;

   typedef struct packed {
      bcc_event_type       event_kind;
      logic [CLICKS_W-1:0] click_count;
      logic                press_edge;
      logic                release_edge;
   } bcc_result_type;

endpackage
`default_nettype wire

// ----- sv/bcc_step.sv -----
// Per-sample classification: next tracking state and the result of one item.
`default_nettype none
module bcc_step #(
   parameter int MAX_CLICKS = bcc_pkg::MAX_CLICKS_DEFAULT
) (
   input  bcc_pkg::bcc_cfg_type             cfg,
   input  bcc_pkg::bcc_state_type           state,
   input  logic                             pin_level,
   input  logic [bcc_pkg::TIME_W-1:0]       now_ms,
   output bcc_pkg::bcc_state_type           state_next,
   output bcc_pkg::bcc_result_type          result
);
   import bcc_pkg::*;

   localparam logic [CLICKS_W-1:0] CLICK_CAP =
      CLICKS_W'((MAX_CLICKS > CLICK_CAP_MAX) ? CLICK_CAP_MAX : MAX_CLICKS);

   logic              active;
   logic [TIME_W-1:0] step_ms;
   logic [TIME_W:0]   held_sum;
   logic [TIME_W-1:0] held_acc;
   logic [TIME_W-1:0] bounce_ext;
   logic [TIME_W-1:0] long_ext;
   logic [TIME_W-1:0] dead_ext;
   logic [TIME_W-1:0] since_click;

   // Map pin polarity and accumulate held time with saturation
   assign active      = cfg.active_low ? ~pin_level : pin_level;
   assign step_ms     = now_ms - state.previous_sample_time;
   assign held_sum    = {1'b0, state.held_duration} + {1'b0, step_ms};
   assign held_acc    = held_sum[TIME_W] ? '1 : held_sum[TIME_W-1:0];
   assign bounce_ext  = TIME_W'(cfg.bounce_time_ms);
   assign long_ext    = TIME_W'(cfg.long_click_time_ms);
   assign dead_ext    = TIME_W'({cfg.bounce_time_ms, 1'b0});
   assign since_click = now_ms - state.last_click_time;

   // Classify the sample
   always_comb begin
      state_next = state;
      state_next.previous_sample_time = now_ms;
      result = '{event_kind: EVT_NONE, click_count: '0, press_edge: 1'b0,
                 release_edge: 1'b0};

      if (active) begin
         state_next.held_duration = held_acc;
         if (held_acc > long_ext && !state.long_reported) begin
            result.event_kind = EVT_LONG_PRESS;
            state_next.long_reported = 1'b1;
         end
         if (!state.press_reported && cfg.press_notify_enable && held_acc > bounce_ext) begin
            state_next.press_reported = 1'b1;
            result.press_edge = 1'b1;
         end
      end else begin
         state_next.press_reported = 1'b0;
         state_next.long_reported  = 1'b0;
         state_next.held_duration  = '0;
         result.release_edge = cfg.release_notify_enable && (state.held_duration > bounce_ext);

         // Long click clears the burst; short click extends it; otherwise check dead time
         if (state.held_duration > long_ext) begin
            result.event_kind = EVT_LONG_CLICK;
            state_next.last_click_time = now_ms;
            state_next.short_clicks = '0;
         end else if (state.held_duration > bounce_ext) begin
            if (state.short_clicks < CLICK_CAP) begin
               state_next.short_clicks = state.short_clicks + 1'b1;
            end
            state_next.last_click_time = now_ms;
         end else if (since_click > dead_ext && state.short_clicks != '0) begin
            result.event_kind  = EVT_BURST_END;
            result.click_count = state.short_clicks;
            state_next.short_clicks = '0;
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/button_click_classifier_top.sv -----
// Top level of the button click classifier: handshakes, registers and result stage.
//
// Usage: each req_ item carries one pin sample (req_pin_level) and a free-running
// millisecond timestamp (req_now_ms). Every accepted item yields exactly one
// rsp_ item: the event code (none, long press held, long click released,
// click burst ended), the click count of an ended burst, and the debounced
// press and release edge flags.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle while req_ready is high (see Stall); the tracking
// state is computed from the sample and the held-time add and compares.
// Stall: a result waits in the output register; a new item is taken in the
// same cycle that the waiting result is taken, so req_ready drops only while
// a result is held and rsp_ready is low.
// Configuration: APB-style writes at byte address 4*index; reads return the
// register. Write only while no item is in flight.
// Reset: clears the tracking state and the result valid flag and restores the
// register defaults (bounce 50 ms, long click 1000 ms, active low).
`default_nettype none
module button_click_classifier_top #(
   parameter int MAX_CLICKS = bcc_pkg::MAX_CLICKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Sample channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_pin_level,
   input  logic [bcc_pkg::TIME_W-1:0]        req_now_ms,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_event_kind,
   output logic [bcc_pkg::CLICKS_W-1:0]      rsp_click_count,
   output logic                              rsp_press_edge,
   output logic                              rsp_release_edge,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bcc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bcc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bcc_pkg::*;

   bcc_cfg_type    cfg_ff, cfg_in;
   bcc_state_type  state_ff, state_in;
   bcc_result_type result_ff, result_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_accept;
   logic           csr_write;
   bcc_reg_type    csr_index;

   // Handshakes
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = bcc_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BOUNCE_TIME:     cfg_in.bounce_time_ms        = csr_pwdata[CFG_TIME_W-1:0];
            REG_LONG_CLICK_TIME: cfg_in.long_click_time_ms    = csr_pwdata[CFG_TIME_W-1:0];
            REG_ACTIVE_LOW:      cfg_in.active_low            = csr_pwdata[0];
            REG_PRESS_NOTIFY:    cfg_in.press_notify_enable   = csr_pwdata[0];
            REG_RELEASE_NOTIFY:  cfg_in.release_notify_enable = csr_pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_index)
         REG_BOUNCE_TIME:     csr_prdata = CSR_DATA_W'(cfg_ff.bounce_time_ms);
         REG_LONG_CLICK_TIME: csr_prdata = CSR_DATA_W'(cfg_ff.long_click_time_ms);
         REG_ACTIVE_LOW:      csr_prdata = CSR_DATA_W'(cfg_ff.active_low);
         REG_PRESS_NOTIFY:    csr_prdata = CSR_DATA_W'(cfg_ff.press_notify_enable);
         REG_RELEASE_NOTIFY:  csr_prdata = CSR_DATA_W'(cfg_ff.release_notify_enable);
         default:             csr_prdata = '0;
      endcase
   end

   // Classify the incoming sample
   bcc_state_type  state_step;
   bcc_result_type result_step;

   bcc_step #(
      .MAX_CLICKS (MAX_CLICKS)
   ) u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .pin_level  (req_pin_level),
      .now_ms     (req_now_ms),
      .state_next (state_step),
      .result     (result_step)
   );

   // Advance state and load the result stage on accept
   always_comb begin
      state_in     = state_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         state_in     = state_step;
         result_in    = result_step;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{bounce_time_ms: BOUNCE_TIME_RESET,
                     long_click_time_ms: LONG_CLICK_TIME_RESET,
                     active_low: 1'b1,
                     press_notify_enable: 1'b0,
                     release_notify_enable: 1'b0};
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = result_ff.event_kind;
   assign rsp_click_count  = result_ff.click_count;
   assign rsp_press_edge   = result_ff.press_edge;
   assign rsp_release_edge = result_ff.release_edge;

endmodule
`default_nettype wire

// ----- tb/tb_button_click_classifier_top.sv -----
// Self-checking testbench for the button click classifier: directed table, then random gestures.
module tb_button_click_classifier_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bcc_pkg::*;

   localparam int CYCLE_LIMIT    = 200_000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 105;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int CLICK_CAP      = (MAX_CLICKS_DEFAULT > CLICK_CAP_MAX) ?
                                   CLICK_CAP_MAX : MAX_CLICKS_DEFAULT;

   typedef struct {
      logic              pin;
      logic [TIME_W-1:0] now;
      bit                fixed;
      bcc_result_type    res;
   } sample_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_pin_level;
   logic [TIME_W-1:0]     req_now_ms;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_event_kind;
   logic [CLICKS_W-1:0]   rsp_click_count;
   logic                  rsp_press_edge;
   logic                  rsp_release_edge;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the registers and of the click tracking state
   bcc_cfg_type       cfg;
   logic [TIME_W-1:0] held_ms;
   logic [TIME_W-1:0] last_sample_ms;
   logic [TIME_W-1:0] last_click_ms;
   logic              long_seen;
   logic              press_seen;
   logic [CLICKS_W-1:0] click_tally;

   bcc_result_type    expected_results[$];
   sample_row_type    stim_rows[$];
   logic [TIME_W-1:0] now_cursor;
   int                error_count;
   int                items_sent;
   int                settings_used;
   int                stall_cycles;
   int                long_presses, long_clicks, burst_ends, largest_burst;
   int                press_edges, release_edges;
   bit                sender_idles;
   bit                receiver_idles;
   int                holdoffs_asked;
   int                holdoffs_done;
   int                holdoff_left;

   button_click_classifier_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_level    (req_pin_level),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_click_count  (rsp_click_count),
      .rsp_press_edge   (rsp_press_edge),
      .rsp_release_edge (rsp_release_edge),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Classify one sample and advance the shadow state
   function automatic bcc_result_type classify_sample(input logic pin,
                                                      input logic [TIME_W-1:0] now);
      bcc_result_type    res;
      logic              active;
      logic [TIME_W:0]   sum;
      logic [TIME_W-1:0] bounce;
      logic [TIME_W-1:0] long_ms;
      logic [TIME_W-1:0] dead;
      bounce  = {16'd0, cfg.bounce_time_ms};
      long_ms = {16'd0, cfg.long_click_time_ms};
      dead    = bounce << 1;
      res     = '{EVT_NONE, '0, 1'b0, 1'b0};
      active  = cfg.active_low ? ~pin : pin;
      if (active) begin
         // accumulate held time, saturating
         sum = {1'b0, held_ms} + {1'b0, now - last_sample_ms};
         held_ms = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
         if (held_ms > long_ms && !long_seen) begin
            res.event_kind = EVT_LONG_PRESS;
            long_seen = 1'b1;
         end
         if (!press_seen && cfg.press_notify_enable && held_ms > bounce) begin
            press_seen = 1'b1;
            res.press_edge = 1'b1;
         end
      end else begin
         press_seen = 1'b0;
         if (cfg.release_notify_enable && held_ms > bounce) res.release_edge = 1'b1;
         // a long click drops any pending burst
         if (held_ms > long_ms) begin
            res.event_kind = EVT_LONG_CLICK;
            last_click_ms = now;
            click_tally = '0;
         end
         if (held_ms > bounce && held_ms <= long_ms) begin
            if (click_tally < CLICK_CAP) click_tally = click_tally + 1'b1;
            last_click_ms = now;
         end
         if ((now - last_click_ms) > dead && click_tally != 0) begin
            res.event_kind  = EVT_BURST_END;
            res.click_count = click_tally;
            click_tally = '0;
         end
         long_seen = 1'b0;
         held_ms = '0;
      end
      last_sample_ms = now;
      return res;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Offer one item, wait for it to be taken, then queue its expected result
   task automatic send_item(input logic pin, input logic [TIME_W-1:0] now,
                            input bit fixed, input bcc_result_type fixed_res);
      bcc_result_type res;
      while (sender_idles && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_pin_level <= pin;
      req_now_ms    <= now;
      do @(posedge clock); while (req_ready !== 1'b1);
      res = classify_sample(pin, now);
      expected_results.push_back(fixed ? fixed_res : res);
      items_sent++;
      @(negedge clock);
   endtask

   // Spread a span of time in one pin state over a few samples
   task automatic advance_level(input bit active, input int unsigned span,
                                input int unsigned pieces);
      int unsigned remaining;
      int unsigned step;
      remaining = span;
      for (int unsigned i = 0; i < pieces; i++) begin
         step = (i == pieces - 1) ? remaining : $urandom_range(0, remaining);
         remaining -= step;
         now_cursor += step;
         send_item(active ^ cfg.active_low, now_cursor, 1'b0, '0);
      end
   endtask

   // One press of a given hold, its release, then an idle gap
   task automatic press_release(input int unsigned hold, input int unsigned gap);
      advance_level(1'b1, hold, $urandom_range(1, 4));
      advance_level(1'b0, $urandom_range(0, 2), 1);
      if (gap > 0) advance_level(1'b0, gap, $urandom_range(1, 3));
   endtask

   function automatic int unsigned short_hold();
      int unsigned bounce;
      int unsigned long_ms;
      bounce  = 32'(cfg.bounce_time_ms);
      long_ms = 32'(cfg.long_click_time_ms);
      if (long_ms > bounce) return $urandom_range(bounce + 1, long_ms);
      return $urandom_range(0, bounce);
   endfunction

   function automatic int unsigned gap_ms(input bit wide);
      int unsigned dead;
      dead = 2 * cfg.bounce_time_ms;
      if (wide) return dead + 1 + $urandom_range(0, 200);
      return $urandom_range(0, dead);
   endfunction

   // Register write: setup phase, access phase, then an idle phase
   task automatic csr_write(input bcc_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_BOUNCE_TIME:     cfg.bounce_time_ms        = value[CFG_TIME_W-1:0];
         REG_LONG_CLICK_TIME: cfg.long_click_time_ms    = value[CFG_TIME_W-1:0];
         REG_ACTIVE_LOW:      cfg.active_low            = value[0];
         REG_PRESS_NOTIFY:    cfg.press_notify_enable   = value[0];
         REG_RELEASE_NOTIFY:  cfg.release_notify_enable = value[0];
         default: ;
      endcase
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic add_row(input logic pin, input logic [TIME_W-1:0] now, input int fixed,
                          input bcc_event_type kind, input int count,
                          input int pedge, input int redge);
      sample_row_type row;
      row.pin = pin;
      row.now = now;
      row.fixed = 1'(fixed);
      row.res = '{kind, CLICKS_W'(count), 1'(pedge), 1'(redge)};
      stim_rows.push_back(row);
   endtask

   // Result side: random stalls plus requested long hold-offs
   initial begin
      rsp_ready = 1'b0;
      holdoffs_done = 0;
      holdoff_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else if (holdoffs_asked != holdoffs_done) begin
            holdoffs_done++;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(receiver_idles && $urandom_range(0, 99) < 16);
         end
      end
   end

   // Compare each result against the oldest expectation
   always @(posedge clock) begin
      bcc_result_type want;
      if (req_valid === 1'b1 && req_ready !== 1'b1) stall_cycles++;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: result arrived with no item outstanding", $time);
         end else begin
            want = expected_results.pop_front();
            check_field("event_kind", want.event_kind, rsp_event_kind);
            check_field("click_count", want.click_count, rsp_click_count);
            check_field("press_edge", want.press_edge, rsp_press_edge);
            check_field("release_edge", want.release_edge, rsp_release_edge);
         end
         case (rsp_event_kind)
            EVT_LONG_PRESS: long_presses++;
            EVT_LONG_CLICK: long_clicks++;
            EVT_BURST_END: begin
               burst_ends++;
               if (rsp_click_count > largest_burst) largest_burst = int'(rsp_click_count);
            end
            default: ;
         endcase
         press_edges   += rsp_press_edge;
         release_edges += rsp_release_edge;
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Run timed out after %0d cycles", CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Main sequence
   initial begin
      int          phase;
      int          phase_end;
      int unsigned pick;
      int unsigned n;
      logic [15:0] bounce, long_ms;
      logic        low, pen, ren;

      reset = 1'b1;
      req_valid = 1'b0;
      req_pin_level = 1'b0;
      req_now_ms = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      items_sent = 0;
      settings_used = 0;
      stall_cycles = 0;
      long_presses = 0;
      long_clicks = 0;
      burst_ends = 0;
      largest_burst = 0;
      press_edges = 0;
      release_edges = 0;
      holdoffs_asked = 0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      cfg = '{BOUNCE_TIME_RESET, LONG_CLICK_TIME_RESET, 1'b1, 1'b0, 1'b0};
      held_ms = '0;
      last_sample_ms = '0;
      last_click_ms = '0;
      long_seen = 1'b0;
      press_seen = 1'b0;
      click_tally = '0;
      now_cursor = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: reset timing, active low, both edge flags on
      csr_write(REG_PRESS_NOTIFY, 1);
      csr_write(REG_RELEASE_NOTIFY, 1);
      settings_used++;
      // idle pin right after reset
      add_row(1'b1, 32'h0000_0000, 1, EVT_NONE, 0, 0, 0);
      // first press sample counts from time zero, then a short click
      add_row(1'b0, 32'h0000_001E, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b0, 32'h0000_003C, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_0046, 0, EVT_NONE, 0, 0, 0);
      // dead time passed: burst of one ends
      add_row(1'b1, 32'h0000_00AB, 1, EVT_BURST_END, 1, 0, 0);
      // bounce glitch and a hold of exactly the bounce time
      add_row(1'b0, 32'h0000_00C8, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_00D2, 1, EVT_NONE, 0, 0, 0);
      add_row(1'b0, 32'h0000_0104, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_0105, 0, EVT_NONE, 0, 0, 0);
      // long press held, reported once, then long click
      add_row(1'b0, 32'h0000_012C, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b0, 32'h0000_04EE, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b0, 32'h0000_0578, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_0582, 1, EVT_LONG_CLICK, 0, 0, 1);
      // pending click wiped by a long click
      add_row(1'b0, 32'h0000_058C, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b0, 32'h0000_05C8, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_05D2, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b0, 32'h0000_05DC, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b0, 32'h0000_0A28, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_0A8C, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_0B54, 0, EVT_NONE, 0, 0, 0);
      // time wrap with held time saturating
      add_row(1'b0, 32'hFFFF_FFFF, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b0, 32'h0000_1000, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_1010, 1, EVT_LONG_CLICK, 0, 0, 1);
      // timestamp moving backwards
      add_row(1'b0, 32'h0000_0100, 0, EVT_NONE, 0, 0, 0);
      add_row(1'b1, 32'h0000_0110, 0, EVT_NONE, 0, 0, 0);
      foreach (stim_rows[i])
         send_item(stim_rows[i].pin, stim_rows[i].now, stim_rows[i].fixed, stim_rows[i].res);
      now_cursor = 32'h0000_0110;

      // Random part: one register setting per phase
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         pen = 1'($urandom_range(0, 1));
         ren = 1'($urandom_range(0, 1));
         low = 1'($urandom_range(0, 1));
         case (phase)
            0: begin bounce = 0;     long_ms = 0;     low = 0; pen = 1; ren = 1; end
            1: begin bounce = 16'hFFFF; long_ms = 16'hFFFF; low = 1; pen = 1; ren = 1; end
            2: begin bounce = 20;    long_ms = 300;   low = 0; pen = 1; ren = 0; end
            3: begin bounce = 40;    long_ms = 500;   low = 1; pen = 0; ren = 1; end
            4: begin
               bounce  = 16'($urandom_range(1, 100));
               long_ms = 16'(bounce + $urandom_range(50, 800));
            end
            5: begin bounce = 300;   long_ms = 100;   pen = 1; ren = 1; end
            6: begin
               bounce  = 16'($urandom_range(0, 30));
               long_ms = 16'($urandom_range(0, 400));
            end
            default: begin bounce = 16'hFFFF; long_ms = 0; low = 0; pen = 0; ren = 0; end
         endcase
         csr_write(REG_BOUNCE_TIME, 32'(bounce));
         csr_write(REG_LONG_CLICK_TIME, 32'(long_ms));
         csr_write(REG_ACTIVE_LOW, 32'(low));
         csr_write(REG_PRESS_NOTIFY, 32'(pen));
         csr_write(REG_RELEASE_NOTIFY, 32'(ren));
         settings_used++;

         // sometimes start just short of the timestamp wrap
         if ($urandom_range(0, 2) == 0) now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 4000);
         // one phase runs with no idling and a long result hold-off
         sender_idles   = (phase != 3);
         receiver_idles = (phase != 3);
         if (phase == 3) holdoffs_asked++;

         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               // noise: random pin, small steps or arbitrary jumps
               n = $urandom_range(1, 4);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0) now_cursor = $urandom;
                  else now_cursor += $urandom_range(0, 5);
                  send_item(1'($urandom_range(0, 1)), now_cursor, 1'b0, '0);
               end
            end else if (pick < 30) begin
               // burst of clicks, often past the count limit
               n = $urandom_range(3, 18);
               repeat (n) press_release(short_hold(), gap_ms(1'b0));
               press_release(short_hold(), gap_ms(1'b1));
            end else if (pick < 60) begin
               press_release(short_hold(), gap_ms(1'($urandom_range(0, 1))));
            end else if (pick < 80) begin
               press_release(cfg.long_click_time_ms + 1 + $urandom_range(0, 300),
                             gap_ms(1'($urandom_range(0, 1))));
            end else begin
               press_release($urandom_range(0, cfg.bounce_time_ms),
                             gap_ms(1'($urandom_range(0, 1))));
            end
         end
      end
      settle();

      $display("Covered %0d samples over %0d register settings; input stalled %0d cycles.",
               items_sent, settings_used, stall_cycles);
      $display("Seen %0d long presses, %0d long clicks, %0d burst ends (up to %0d clicks),",
               long_presses, long_clicks, burst_ends, largest_burst);
      $display("and %0d press / %0d release edges.", press_edges, release_edges);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
